// File: hdl/tkd_pkg.sv
// Package for the telnet terminal key decoder.
// Byte codes, key-event codes and the result beat type; no dependencies.
package tkd_pkg;

    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 5;
    localparam int CHAR_W  = 7;

    // telnet command bytes
    localparam logic [BYTE_W-1:0] TN_IAC  = 8'hFF;
    localparam logic [BYTE_W-1:0] TN_DONT = 8'hFE;
    localparam logic [BYTE_W-1:0] TN_DO   = 8'hFD;
    localparam logic [BYTE_W-1:0] TN_WONT = 8'hFC;
    localparam logic [BYTE_W-1:0] TN_WILL = 8'hFB;
    localparam logic [BYTE_W-1:0] TN_SB   = 8'hFA;
    localparam logic [BYTE_W-1:0] TN_SE   = 8'hF0;

    // terminal bytes
    localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CTRL_W = 8'h17;
    localparam logic [BYTE_W-1:0] CH_CTRL_K = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_SS3    = 8'h4F;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7E;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE       = 5'd0,
        EV_INSERT     = 5'd1,
        EV_ENTER      = 5'd2,
        EV_BACKSPACE  = 5'd3,
        EV_HOME       = 5'd4,
        EV_LEFT       = 5'd5,
        EV_CANCEL     = 5'd6,
        EV_EOF_DEL    = 5'd7,
        EV_END        = 5'd8,
        EV_RIGHT      = 5'd9,
        EV_TAB        = 5'd10,
        EV_KILL_END   = 5'd11,
        EV_CLEAR      = 5'd12,
        EV_HIST_NEXT  = 5'd13,
        EV_HIST_PREV  = 5'd14,
        EV_KILL_LINE  = 5'd15,
        EV_KILL_WORD  = 5'd16,
        EV_DELETE     = 5'd17
    } t_key_event;

    typedef struct packed {
        t_key_event              key_event;
        logic [CHAR_W-1:0]       key_char;
    } t_key_beat;

endpackage

// File: hdl/tkd_if.sv
// Valid/ready channel interfaces for the key decoder.
// Depends on tkd_pkg for field widths.
interface tkd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [tkd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tkd_key_if;
    logic                        valid;
    logic                        ready;
    logic [tkd_pkg::EVENT_W-1:0] key_event;
    logic [tkd_pkg::CHAR_W-1:0]  key_char;

    modport source (output valid, output key_event, output key_char, input ready);
    modport sink   (input valid, input key_event, input key_char, output ready);
endinterface

// File: hdl/tkd_decoder.sv
// Decode state machine: telnet stripping, escape parsing, key mapping.
// Depends on tkd_pkg and tkd_if; feeds tkd_out_buf.
module tkd_decoder #(
    parameter int PARAM_BUF_BYTES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tkd_byte_if.sink           i_rx,
    input  logic               i_beat_ready,
    output logic               o_beat_valid,
    output tkd_pkg::t_key_beat o_beat
);
    import tkd_pkg::*;

    localparam int CNT_W = $clog2(PARAM_BUF_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PARAM_BUF_BYTES - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ESC, ST_CSI, ST_IAC, ST_IAC_CMD, ST_SB, ST_SB_IAC
    } t_dec_state;

    t_dec_state       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_value, n_value;
    logic             r_closed, n_closed;

    logic             accept;
    logic [7:0]       b;
    t_key_event       ev;
    logic [CHAR_W-1:0] ch;
    logic [11:0]      acc;

    assign i_rx.ready = i_beat_ready;
    assign accept     = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;
    assign acc        = {4'd0, r_value} * 12'd10 + {8'd0, b[3:0]};

    function automatic t_key_event idle_event(input logic [7:0] c);
        t_key_event e;
        e = EV_NONE;
        case (c)
            8'h0D, 8'h0A:    e = EV_ENTER;
            CH_DEL, 8'h08:   e = EV_BACKSPACE;
            8'h01:           e = EV_HOME;
            8'h02:           e = EV_LEFT;
            8'h03:           e = EV_CANCEL;
            8'h04:           e = EV_EOF_DEL;
            8'h05:           e = EV_END;
            8'h06:           e = EV_RIGHT;
            8'h09:           e = EV_TAB;
            CH_CTRL_K:       e = EV_KILL_END;
            8'h0C:           e = EV_CLEAR;
            8'h0E:           e = EV_HIST_NEXT;
            8'h10:           e = EV_HIST_PREV;
            8'h15:           e = EV_KILL_LINE;
            CH_CTRL_W:       e = EV_KILL_WORD;
            default: begin
                if (c >= CH_SPACE && c < CH_DEL) e = EV_INSERT;
            end
        endcase
        return e;
    endfunction

    function automatic t_key_event csi_final(input logic [7:0] c,
                                             input logic       has_param,
                                             input logic [7:0] val);
        t_key_event e;
        e = EV_NONE;
        case (c)
            8'h41: e = EV_HIST_PREV;   // A
            8'h42: e = EV_HIST_NEXT;   // B
            8'h43: e = EV_RIGHT;       // C
            8'h44: e = EV_LEFT;        // D
            8'h48: e = EV_HOME;        // H
            8'h46: e = EV_END;         // F
            CH_TILDE: begin
                if (has_param) begin
                    if (val == 8'd1)      e = EV_HOME;
                    else if (val == 8'd3) e = EV_DELETE;
                    else if (val == 8'd4) e = EV_END;
                end
            end
            default: e = EV_NONE;
        endcase
        return e;
    endfunction

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_value  = r_value;
        n_closed = r_closed;
        ev       = EV_NONE;
        ch       = '0;
        case (r_state)
            ST_IAC: begin
                if (b == TN_WILL || b == TN_WONT || b == TN_DO || b == TN_DONT) begin
                    n_state = ST_IAC_CMD;
                end else if (b == TN_SB) begin
                    n_state = ST_SB;
                end else begin
                    n_state = ST_IDLE;   // IAC IAC and unknown commands
                end
            end
            ST_IAC_CMD: begin
                n_state = ST_IDLE;       // option byte swallowed
            end
            ST_SB: begin
                if (b == TN_IAC) n_state = ST_SB_IAC;
            end
            ST_SB_IAC: begin
                n_state = (b == TN_SE) ? ST_IDLE : ST_SB;
            end
            ST_ESC: begin
                if (b == TN_IAC) begin
                    n_state = ST_IAC;
                end else if (b == CH_LBRACK || b == CH_SS3) begin
                    n_state = ST_CSI;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_CSI: begin
                if (b == TN_IAC) begin
                    n_state = ST_IAC;
                end else if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI) begin
                    if (r_count < CNT_MAX) begin
                        n_count = r_count + 1'b1;
                        if (b == CH_SEMI) begin
                            n_closed = 1'b1;
                        end else if (!r_closed) begin
                            n_value = (acc > 12'd255) ? 8'd255 : acc[7:0];
                        end
                    end
                end else begin
                    ev       = csi_final(b, r_count != '0, r_value);
                    n_state  = ST_IDLE;
                    n_count  = '0;
                    n_value  = '0;
                    n_closed = 1'b0;
                end
            end
            default: begin
                // idle, and the unused code behaves as idle
                if (b == TN_IAC) begin
                    n_state = ST_IAC;
                end else if (b == CH_ESC) begin
                    n_state  = ST_ESC;
                    n_count  = '0;
                    n_value  = '0;
                    n_closed = 1'b0;
                end else begin
                    n_state = ST_IDLE;
                    ev      = idle_event(b);
                    if (ev == EV_INSERT) ch = b[CHAR_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_value  <= '0;
            r_closed <= 1'b0;
        end else if (accept) begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_value  <= n_value;
            r_closed <= n_closed;
        end
    end

    assign o_beat_valid     = accept;
    assign o_beat.key_event = ev;
    assign o_beat.key_char  = ch;

    // non-insert events never carry a character
    a_char_only_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_beat_valid && o_beat.key_event != EV_INSERT |-> o_beat.key_char == '0)
        else $error("key_char set on a non-insert event");

    // ESC from idle starts a sequence with cleared parameters
    a_esc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_state == ST_IDLE && b == CH_ESC
        |=> r_state == ST_ESC && r_count == '0 && r_value == '0 && !r_closed)
        else $error("escape entry did not clear parameters");

    // parameter count saturates
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("parameter count past its limit");

endmodule

// File: hdl/tkd_out_buf.sv
// Two-entry result register: output stage plus skid entry.
// Depends on tkd_pkg and tkd_if.
module tkd_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  tkd_pkg::t_key_beat i_beat,
    output logic               o_ready,
    tkd_key_if.source          o_key
);
    import tkd_pkg::*;

    logic      r_main_valid, r_skid_valid;
    t_key_beat r_main, r_skid;
    logic      pop;

    assign o_ready = !r_skid_valid;
    assign pop     = r_main_valid && o_key.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_valid;
                r_main       <= i_beat;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
            r_skid       <= i_beat;
        end
    end

    assign o_key.valid     = r_main_valid;
    assign o_key.key_event = r_main.key_event;
    assign o_key.key_char  = r_main.key_char;

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held with empty output stage");

    // a beat taken with a stalled full output lands in the skid entry
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && r_main_valid && !o_key.ready |=> r_skid_valid)
        else $error("beat lost while output stalled");

endmodule

// File: hdl/telnet_terminal_key_decoder.sv
// Top level of the telnet terminal key decoder.
// Depends on tkd_pkg, tkd_if, tkd_decoder and tkd_out_buf.
//
// Takes one raw byte per beat on i_rx and gives exactly one key-event beat
// on o_key for each byte, in order. Telnet IAC commands (WILL/WONT/DO/DONT
// plus option, SB..IAC SE) are stripped, ESC [ and ESC O sequences are
// parsed with the leading CSI number saturated at 255, and control and
// printable bytes map to editing events; consumed bytes give event "none".
// Throughput is one byte per clock while i_rx.ready is high: the decode state
// machine updates in the cycle a byte is accepted and the event is registered
// in the output stage, or in the skid entry while o_key stalls. The result
// side is a two-entry register (output stage plus skid entry), so i_rx.ready
// stays high while one result waits and drops only when two are pending; it
// is a register, not a path from o_key.ready. With PARAM_BUF_BYTES (2..32),
// up to PARAM_BUF_BYTES - 1 CSI parameter bytes count; later ones are dropped.
module telnet_terminal_key_decoder #(
    parameter int PARAM_BUF_BYTES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tkd_byte_if.sink  i_rx,
    tkd_key_if.source o_key
);
    import tkd_pkg::*;

    logic      beat_valid;
    logic      beat_ready;
    t_key_beat beat;

    tkd_decoder #(
        .PARAM_BUF_BYTES (PARAM_BUF_BYTES)
    ) u_decoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_beat_ready (beat_ready),
        .o_beat_valid (beat_valid),
        .o_beat       (beat)
    );

    tkd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (beat_valid),
        .i_beat  (beat),
        .o_ready (beat_ready),
        .o_key   (o_key)
    );

endmodule

// File: test/tkd_key_checker.sv
// Checker for the telnet terminal key decoder: predicts one key beat per byte.
// Depends on tkd_pkg and the channel interfaces in tkd_if.
module tkd_key_checker #(
    parameter int PARAM_BUF_BYTES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tkd_byte_if  i_rx,
    tkd_key_if   i_key,
    output int   o_fail_count,
    output int   o_pending
);
    import tkd_pkg::*;

    typedef enum logic [2:0] {
        DS_IDLE    = 3'd0,
        DS_ESC     = 3'd1,
        DS_CSI     = 3'd2,
        DS_IAC     = 3'd3,
        DS_IAC_CMD = 3'd4,
        DS_SB      = 3'd5,
        DS_SB_IAC  = 3'd6
    } t_decode_state;

    t_decode_state   dec_state;
    int              param_cnt;
    logic [7:0]      param_val;
    logic            param_semi;
    t_key_beat       key_q[$];
    int              fails = 0;

    // Advances the decoder copy by one byte and returns the key it yields.
    function automatic t_key_beat predict_key(input logic [BYTE_W-1:0] b);
        t_key_beat beat;
        int        acc;
        beat.key_event = EV_NONE;
        beat.key_char  = '0;
        case (dec_state)
            DS_IAC: begin
                if (b >= TN_WILL && b <= TN_DONT) dec_state = DS_IAC_CMD;
                else if (b == TN_SB)              dec_state = DS_SB;
                else                              dec_state = DS_IDLE;
            end
            DS_IAC_CMD: dec_state = DS_IDLE;
            DS_SB:      if (b == TN_IAC) dec_state = DS_SB_IAC;
            DS_SB_IAC:  dec_state = (b == TN_SE) ? DS_IDLE : DS_SB;
            default: begin
                if (b == TN_IAC) begin
                    dec_state = DS_IAC;
                end else if (dec_state == DS_ESC) begin
                    dec_state = (b == CH_LBRACK || b == CH_SS3) ? DS_CSI : DS_IDLE;
                end else if (dec_state == DS_CSI) begin
                    if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI) begin
                        if (param_cnt < PARAM_BUF_BYTES - 1) begin
                            param_cnt++;
                            if (b == CH_SEMI) begin
                                param_semi = 1'b1;
                            end else if (!param_semi) begin
                                acc = int'(param_val) * 10 + int'(b - CH_ZERO);
                                param_val = (acc > 255) ? 8'hFF : 8'(acc);
                            end
                        end
                    end else begin
                        case (b)
                            "A": beat.key_event = EV_HIST_PREV;
                            "B": beat.key_event = EV_HIST_NEXT;
                            "C": beat.key_event = EV_RIGHT;
                            "D": beat.key_event = EV_LEFT;
                            "H": beat.key_event = EV_HOME;
                            "F": beat.key_event = EV_END;
                            CH_TILDE: begin
                                if (param_cnt != 0) begin
                                    if (param_val == 8'd1)      beat.key_event = EV_HOME;
                                    else if (param_val == 8'd3) beat.key_event = EV_DELETE;
                                    else if (param_val == 8'd4) beat.key_event = EV_END;
                                end
                            end
                            default: ;
                        endcase
                        dec_state  = DS_IDLE;
                        param_cnt  = 0;
                        param_val  = '0;
                        param_semi = 1'b0;
                    end
                end else begin
                    // idle, and the unused state code behaves the same
                    dec_state = DS_IDLE;
                    if (b == CH_ESC) begin
                        dec_state  = DS_ESC;
                        param_cnt  = 0;
                        param_val  = '0;
                        param_semi = 1'b0;
                    end else begin
                        case (b)
                            8'h0D, 8'h0A:   beat.key_event = EV_ENTER;
                            CH_DEL, 8'h08:  beat.key_event = EV_BACKSPACE;
                            8'h01:          beat.key_event = EV_HOME;
                            8'h02:          beat.key_event = EV_LEFT;
                            8'h03:          beat.key_event = EV_CANCEL;
                            8'h04:          beat.key_event = EV_EOF_DEL;
                            8'h05:          beat.key_event = EV_END;
                            8'h06:          beat.key_event = EV_RIGHT;
                            8'h09:          beat.key_event = EV_TAB;
                            CH_CTRL_K:      beat.key_event = EV_KILL_END;
                            8'h0C:          beat.key_event = EV_CLEAR;
                            8'h0E:          beat.key_event = EV_HIST_NEXT;
                            8'h10:          beat.key_event = EV_HIST_PREV;
                            8'h15:          beat.key_event = EV_KILL_LINE;
                            CH_CTRL_W:      beat.key_event = EV_KILL_WORD;
                            default: begin
                                if (b >= CH_SPACE && b < CH_DEL) begin
                                    beat.key_event = EV_INSERT;
                                    beat.key_char  = b[CHAR_W-1:0];
                                end
                            end
                        endcase
                    end
                end
            end
        endcase
        return beat;
    endfunction

    always @(posedge i_clk) begin : watch
        t_key_beat want;
        if (!i_rst_n) begin
            dec_state  = DS_IDLE;
            param_cnt  = 0;
            param_val  = '0;
            param_semi = 1'b0;
            key_q.delete();
        end else begin
            // results are registered and never leave in their own byte's cycle, so check before queuing
            if (i_key.valid && i_key.ready) begin
                if (key_q.size() == 0) begin
                    $error("key beat with nothing pending: key_event %0d key_char %0d",
                           i_key.key_event, i_key.key_char);
                    fails++;
                end else begin
                    want = key_q.pop_front();
                    if (i_key.key_event !== want.key_event) begin
                        $error("key_event: expected %0d, got %0d",
                               want.key_event, i_key.key_event);
                        fails++;
                    end
                    if (i_key.key_char !== want.key_char) begin
                        $error("key_char: expected %0d, got %0d",
                               want.key_char, i_key.key_char);
                        fails++;
                    end
                end
            end
            if (i_rx.valid && i_rx.ready) key_q.push_back(predict_key(i_rx.rx_byte));
        end
        o_fail_count <= fails;
        o_pending    <= key_q.size();
    end

endmodule

// File: test/tb_top.sv
// Top of the key decoder testbench: clock, reset, byte stimulus, key sink.
// Depends on tkd_pkg, tkd_if, the decoder RTL and tkd_key_checker.
module tb_top;
    import tkd_pkg::*;

    localparam int PARAM_BUF_BYTES = 8;
    localparam int NUM_BYTES       = 2000;
    localparam int HOLD_CYCLES     = 300;   // long sink stall, fills the skid entry
    localparam int HOLD_AT         = 500;   // byte count that triggers the stall
    localparam int QUIET_FROM      = 900;   // no idling on either side in this window
    localparam int QUIET_TO        = 1300;
    localparam int DRAIN_CYCLES    = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tkd_byte_if rx_ch ();
    tkd_key_if  key_ch ();

    int fail_count;
    int pending;

    // shared between the two sides
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int sent     = 0;

    // CSI/SS3 final bytes, tilde weighted up so the entry codes get hit often
    logic [7:0] csi_finals [0:7] = '{"A", "B", "C", "D", "H", "F", CH_TILDE, CH_TILDE};

    telnet_terminal_key_decoder #(
        .PARAM_BUF_BYTES (PARAM_BUF_BYTES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_key   (key_ch)
    );

    tkd_key_checker #(
        .PARAM_BUF_BYTES (PARAM_BUF_BYTES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_ch),
        .i_key        (key_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake hangs.
    initial begin
        #(8 * 400000);
        $display("tb: failure");
        $finish;
    end

    // Offer one byte, with random idle cycles ahead of it, and wait for the beat.
    // valid stays high into the next call when that call does not idle.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        idle_on = !(sent >= QUIET_FROM && sent < QUIET_TO);
        while (idle_on && $urandom_range(99) < 29) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        sent++;
        if (sent == HOLD_AT) hold_req = 1'b1;
    endtask

    // Sink side: random back-pressure, plus one long hold on request so the
    // two-entry output register fills and the decoder drops i_rx.ready.
    initial begin
        key_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    key_ch.ready <= 1'b0;
                    @(posedge i_clk);
                end
            end else begin
                key_ch.ready <= !(idle_on && $urandom_range(99) < 29);
                @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [7:0] seq[$];
        int         pick;
        int         n;
        int         r;

        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, a high byte in idle, DEL, space, ESC ESC,
        // ESC [ 3 ~ (delete), a tilde with no parameter, IAC while in a
        // sequence followed by IAC IAC, IAC DO with option, and a
        // subnegotiation holding an IAC that is not followed by SE.
        seq = '{8'h00, 8'hFE, CH_DEL, CH_SPACE,
                CH_ESC, CH_ESC,
                CH_ESC, CH_LBRACK, CH_ZERO + 8'd3, CH_TILDE,
                CH_ESC, CH_LBRACK, CH_TILDE,
                CH_ESC, CH_SS3, TN_IAC, TN_IAC, TN_IAC,
                TN_DO, 8'h01,
                TN_IAC, TN_SB, TN_IAC, 8'h01, TN_IAC, TN_SE};
        foreach (seq[k]) send_byte(seq[k]);

        // Random: mostly well-formed escape and telnet sequences with random
        // content, the rest single bytes and broken sequences.
        while (sent < NUM_BYTES) begin
            seq.delete();
            pick = $urandom_range(99);
            if (pick < 35) begin
                // ESC [ / ESC O with parameters; sometimes a bad introducer
                seq.push_back(CH_ESC);
                r = $urandom_range(9);
                seq.push_back(r < 4 ? CH_LBRACK : r < 8 ? CH_SS3 : 8'($urandom_range(255)));
                if ($urandom_range(1) == 1) begin
                    r = $urandom_range(2);
                    seq.push_back(CH_ZERO + 8'(r == 0 ? 1 : r + 2));
                end
                // mostly short parameter runs; some overflow the count or saturate
                n = ($urandom_range(3) == 0) ? $urandom_range(10) : $urandom_range(2);
                repeat (n) begin
                    seq.push_back($urandom_range(4) == 0 ? CH_SEMI
                                                         : CH_ZERO + 8'($urandom_range(9)));
                end
                r = $urandom_range(9);
                seq.push_back(r < 8 ? csi_finals[$urandom_range(7)] : 8'($urandom_range(255)));
            end else if (pick < 55) begin
                // IAC command: option verbs, escaped 0xFF, or an unknown command
                seq.push_back(TN_IAC);
                r = $urandom_range(9);
                if (r < 6) begin
                    seq.push_back(TN_WILL + 8'($urandom_range(3)));
                    seq.push_back(8'($urandom_range(255)));
                end else if (r < 8) begin
                    seq.push_back(TN_IAC);
                end else begin
                    seq.push_back(8'($urandom_range(255)));
                end
            end else if (pick < 70) begin
                // subnegotiation with random payload, closed by IAC SE
                seq.push_back(TN_IAC);
                seq.push_back(TN_SB);
                repeat ($urandom_range(6)) begin
                    if ($urandom_range(5) == 0) seq.push_back(TN_IAC);
                    seq.push_back(8'($urandom_range(255)));
                end
                seq.push_back(TN_IAC);
                seq.push_back(TN_SE);
            end else begin
                // loose bytes, half of them from the 7-bit range
                repeat (1 + $urandom_range(3)) begin
                    seq.push_back(8'($urandom_range($urandom_range(1) ? 255 : 127)));
                end
            end
            foreach (seq[k]) send_byte(seq[k]);
        end

        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
